>>> src/imu_bias_alignment_calibrator_core_assert.svh
// Assertion macros used by the checker file of the calibrator.
`ifndef IMU_BIAS_ALIGNMENT_CALIBRATOR_CORE_ASSERT_SVH
`define IMU_BIAS_ALIGNMENT_CALIBRATOR_CORE_ASSERT_SVH
// Checked on every rising clock edge outside reset.
`define IBAC_ASSERT(lbl, prop) lbl: assert property (@(posedge clock) \
   disable iff (reset) prop) else $error("calibrator assertion failed");
// Checked on every rising clock edge, reset included.
`define IBAC_ASSERT_RST(lbl, prop) lbl: assert property (@(posedge clock) \
   prop) else $error("calibrator reset assertion failed");
`endif

>>> src/ibac_pkg.sv
`timescale 1ns / 1ps
package ibac_pkg;
   localparam int SMP_W = 16;
   localparam int CF_W = 16;
   localparam int NEG_W = SMP_W + 1;
   localparam int ACC_W = 36;
   localparam int ROT_W = 20;
   localparam int SUM_W = 34;
   localparam int CNT_W = 17;
   localparam int MEAN_W = 20;
   localparam int R_W = MEAN_W + 1;
   localparam int NUM_W = 40;
   localparam int DEN_W = 21;
   localparam int Q_W = NUM_W + 1;
   localparam int NSUM = 18;
   localparam int ADDR_W = 5;
   localparam int ROT_BASE = 12;
   localparam int NMEAN = 9;
   localparam int GRAV_W = 15;
   localparam int CSR_IDX_W = 3;

   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_COMPUTE = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] PH_STATIC = 2'd1;
   localparam logic [1:0] PH_ROT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_COS_FIRST = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SIN_FIRST = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COS_SECOND = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SIN_SECOND = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GRAVITY = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_ROT = 3'd5;

   localparam logic signed [CF_W-1:0] RST_COS_FIRST = 16'sd15964;
   localparam logic signed [CF_W-1:0] RST_SIN_FIRST = 16'sd3686;
   localparam logic signed [CF_W-1:0] RST_COS_SECOND = 16'sd15826;
   localparam logic signed [CF_W-1:0] RST_SIN_SECOND = 16'sd4240;
   localparam logic [GRAV_W-1:0] RST_GRAVITY = 15'd10045;
   localparam logic [GRAV_W-1:0] RST_MIN_ROT = 15'd1;

   typedef logic signed [SMP_W-1:0] smp_type;

   // Partial product of one coefficient bit; the sign bit carries negative weight.
   function automatic logic signed [ACC_W-1:0] pp(input logic signed [ACC_W-1:0] sh,
                                                  input logic b, input logic neg);
      logic signed [ACC_W-1:0] r;
      r = b ? (neg ? -sh : sh) : '0;
      return r;
   endfunction

   function automatic logic signed [SMP_W-1:0] sat16(input logic signed [Q_W-1:0] v);
      logic signed [SMP_W-1:0] r;
      if (v > Q_W'(32767)) r = 16'sh7fff;
      else if (v < -Q_W'(32768)) r = 16'sh8000;
      else r = v[SMP_W-1:0];
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [Q_W-1:0] v);
      logic signed [31:0] r;
      if (v > Q_W'(64'sd2147483647)) r = 32'sh7fffffff;
      else if (v < -Q_W'(64'sd2147483648)) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] sum_addr(input logic s, input logic rot,
                                                  input logic [2:0] k);
      logic [ADDR_W-1:0] a;
      a = rot ? ADDR_W'(ROT_BASE + 3 * int'(s) + int'(k)) : ADDR_W'(6 * int'(s) + int'(k));
      return a;
   endfunction
endpackage

>>> src/ibac_if.sv
`timescale 1ns / 1ps
interface ibac_req_if;
   logic valid;
   logic ready;
   logic [1:0] command;
   logic sensor;
   logic [1:0] phase;
   ibac_pkg::smp_type gyro_x, gyro_y, gyro_z;
   ibac_pkg::smp_type accel_x, accel_y, accel_z;
   modport source (output valid, command, sensor, phase, gyro_x, gyro_y, gyro_z,
                   accel_x, accel_y, accel_z, input ready);
   modport sink (input valid, command, sensor, phase, gyro_x, gyro_y, gyro_z,
                 accel_x, accel_y, accel_z, output ready);
endinterface

interface ibac_rsp_if;
   logic valid;
   logic ready;
   logic result_sensor;
   logic valid_res;
   ibac_pkg::smp_type accel_bias_x, accel_bias_y, accel_bias_z;
   ibac_pkg::smp_type gyro_bias_x, gyro_bias_y, gyro_bias_z;
   logic signed [31:0] proj_z_to_x, proj_z_to_y;
   logic last;
   modport source (output valid, result_sensor, valid_res, accel_bias_x, accel_bias_y,
                   accel_bias_z, gyro_bias_x, gyro_bias_y, gyro_bias_z, proj_z_to_x,
                   proj_z_to_y, last, input ready);
   modport sink (input valid, result_sensor, valid_res, accel_bias_x, accel_bias_y,
                 accel_bias_z, gyro_bias_x, gyro_bias_y, gyro_bias_z, proj_z_to_x,
                 proj_z_to_y, last, output ready);
endinterface

>>> src/ibac_ram.sv
`timescale 1ns / 1ps
module ibac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end
   assign rdata = rdata_ff;
endmodule

>>> src/ibac_rotator.sv
`timescale 1ns / 1ps
module ibac_rotator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [ibac_pkg::NEG_W-1:0]     ax,
   input  logic signed [ibac_pkg::NEG_W-1:0]     az,
   input  logic signed [ibac_pkg::NEG_W-1:0]     gx,
   input  logic signed [ibac_pkg::NEG_W-1:0]     gz,
   input  logic signed [ibac_pkg::CF_W-1:0]      c,
   input  logic signed [ibac_pkg::CF_W-1:0]      s,
   output logic                                  done,
   output logic signed [ibac_pkg::ROT_W-1:0]     ax2,
   output logic signed [ibac_pkg::ROT_W-1:0]     az2,
   output logic signed [ibac_pkg::ROT_W-1:0]     gx2,
   output logic signed [ibac_pkg::ROT_W-1:0]     gz2
);
   import ibac_pkg::*;

   logic busy_ff, done_ff;
   logic [$clog2(CF_W)-1:0] bit_ff;
   logic [CF_W-1:0] c_ff, s_ff;
   logic signed [ACC_W-1:0] axs_ff, azs_ff, gxs_ff, gzs_ff;
   logic signed [ACC_W-1:0] axr_ff, azr_ff, gxr_ff, gzr_ff;
   logic neg, cb, sb;

   function automatic logic signed [ROT_W-1:0] rnd(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W-1:0] t;
      t = a + ACC_W'(8192);
      return t[14+ROT_W-1:14];
   endfunction

   assign neg = (bit_ff == ($clog2(CF_W))'(CF_W - 1));
   assign cb = c_ff[0];
   assign sb = s_ff[0];

   // One coefficient bit per cycle, four lanes side by side.
   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (start) begin
         busy_ff <= 1'b1;
         bit_ff <= '0;
         c_ff <= c;
         s_ff <= s;
         axs_ff <= ACC_W'(ax);
         azs_ff <= ACC_W'(az);
         gxs_ff <= ACC_W'(gx);
         gzs_ff <= ACC_W'(gz);
         axr_ff <= '0;
         azr_ff <= '0;
         gxr_ff <= '0;
         gzr_ff <= '0;
      end else if (busy_ff) begin
         axr_ff <= axr_ff + pp(axs_ff, cb, neg) - pp(azs_ff, sb, neg);
         azr_ff <= azr_ff + pp(axs_ff, sb, neg) + pp(azs_ff, cb, neg);
         gxr_ff <= gxr_ff + pp(gxs_ff, cb, neg) - pp(gzs_ff, sb, neg);
         gzr_ff <= gzr_ff + pp(gxs_ff, sb, neg) + pp(gzs_ff, cb, neg);
         axs_ff <= axs_ff <<< 1;
         azs_ff <= azs_ff <<< 1;
         gxs_ff <= gxs_ff <<< 1;
         gzs_ff <= gzs_ff <<< 1;
         c_ff <= c_ff >> 1;
         s_ff <= s_ff >> 1;
         bit_ff <= bit_ff + 1'b1;
         if (neg) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end
   end

   assign done = done_ff;
   assign ax2 = rnd(axr_ff);
   assign az2 = rnd(azr_ff);
   assign gx2 = rnd(gxr_ff);
   assign gz2 = rnd(gzr_ff);
endmodule

>>> src/ibac_divider.sv
`timescale 1ns / 1ps
module ibac_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [ibac_pkg::NUM_W-1:0] num,
   input  logic signed [ibac_pkg::DEN_W-1:0] den,
   output logic                              done,
   output logic signed [ibac_pkg::Q_W-1:0]   quo
);
   import ibac_pkg::*;

   logic busy_ff, done_ff, neg_ff;
   logic [$clog2(NUM_W)-1:0] cnt_ff;
   logic [NUM_W-1:0] q_ff;
   logic [DEN_W-1:0] rem_ff, ad_ff;
   logic [NUM_W-1:0] an;
   logic [DEN_W-1:0] ad;
   logic [DEN_W:0] shifted;
   logic [DEN_W+1:0] diff;
   logic ge;

   assign an = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   assign ad = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
   assign shifted = {rem_ff, q_ff[NUM_W-1]};
   assign diff = {1'b0, shifted} - {2'b00, ad_ff};
   assign ge = !diff[DEN_W+1];

   // Restoring division, one quotient bit per cycle; halves round away from zero.
   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (start) begin
         busy_ff <= 1'b1;
         cnt_ff <= '0;
         neg_ff <= num[NUM_W-1] ^ den[DEN_W-1];
         ad_ff <= ad;
         rem_ff <= '0;
         q_ff <= an + NUM_W'(ad >> 1);
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         q_ff <= {q_ff[NUM_W-2:0], ge};
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == ($clog2(NUM_W))'(NUM_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end
   end

   assign done = done_ff;
   assign quo = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
endmodule

>>> src/imu_bias_alignment_calibrator_core.sv
`timescale 1ns / 1ps
// Static bias and axis alignment calibrator for two tilted IMUs.
// The req channel carries one command per transaction: a sample, a compute or a
// clear. The rsp channel returns two transactions per compute, the first sensor
// first, with last set on the second. The csr port writes the tilt cosines and
// sines, the gravity offset and the rotation threshold; write only when idle.
// A collected sample passes through the bit-serial rotator; each of its sums,
// six for a static and three for a rotation sample, is then read and written
// back in the sum memory, which has one read and one write port. Discarded
// samples, clears and unused codes are handled in the idle state. Per sensor
// with samples in both sets, a compute runs nine mean divisions and, if the z
// rotation exceeds the threshold, two projection divisions in the shared radix-2
// divider. A new transaction is taken once the last result is registered, even
// while the receiver stalls; a stalled first result holds the second's output.
// Reset restores the register defaults and empties all sums at once through
// per-entry valid bits, so no clearing pass is needed.
module imu_bias_alignment_calibrator_core (
   input  logic                                  clock,
   input  logic                                  reset,
   ibac_req_if.sink                              req,
   ibac_rsp_if.source                            rsp,
   input  logic                                  csr_we,
   input  logic [ibac_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ibac_pkg::CF_W-1:0]             csr_wdata
);
   import ibac_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_ROT, S_ACC_RD, S_ACC_WR, S_CHK, S_C_RD, S_C_LD, S_C_DIV,
      S_P_LD, S_P_DIV, S_OUT
   } state_type;

   state_type state_ff;

   // Configuration registers.
   logic signed [CF_W-1:0] cos_ff [2];
   logic signed [CF_W-1:0] sin_ff [2];
   logic [GRAV_W-1:0] grav_ff, minrot_ff;

   // Sample path.
   logic smp_sensor_ff, smp_rot_ff;
   logic signed [NEG_W-1:0] ay_ff, gy_ff;
   logic signed [SUM_W-1:0] vals_ff [6];
   logic [CNT_W-1:0] scnt_ff [2];
   logic [CNT_W-1:0] rcnt_ff [2];
   logic [NSUM-1:0] valid_ff;
   logic rvld_ff;
   logic [3:0] k_ff;

   // Compute path.
   logic sens_ff, emp_ff, vld_ff, pk_ff;
   logic signed [MEAN_W-1:0] mean_ff [NMEAN];
   logic signed [31:0] px_ff, py_ff;

   // Output register.
   logic o_v_ff, o_sensor_ff, o_valid_ff;
   logic signed [SMP_W-1:0] o_bias_ff [6];
   logic signed [31:0] o_px_ff, o_py_ff;

   logic accept, rot_start, rot_done, div_start, div_done, out_free, full;
   logic signed [NEG_W-1:0] ax_n, az_n, gx_n, gz_n;
   logic signed [ROT_W-1:0] ax2, az2, gx2, gz2;
   logic signed [NUM_W-1:0] div_num;
   logic signed [DEN_W-1:0] div_den;
   logic signed [Q_W-1:0] div_quo;
   logic [ADDR_W-1:0] raddr, acc_addr, cmp_addr;
   logic [SUM_W-1:0] rdata, wdata;
   logic ram_we;
   logic [2:0] sel;
   logic signed [R_W-1:0] rx, ry, rz, rsel;
   logic [R_W-1:0] arz;
   logic signed [NUM_W-1:0] pnum;
   logic signed [SUM_W-1:0] cur_sum;

   assign accept = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign out_free = !o_v_ff || rsp.ready;

   // The y and z axes are negated before the tilt rotation.
   assign ax_n = NEG_W'(req.accel_x);
   assign az_n = -NEG_W'(req.accel_z);
   assign gx_n = NEG_W'(req.gyro_x);
   assign gz_n = -NEG_W'(req.gyro_z);

   always_comb begin
      full = 1'b1;
      if (req.phase == PH_STATIC) full = scnt_ff[req.sensor][CNT_W-1];
      else if (req.phase == PH_ROT) full = rcnt_ff[req.sensor][CNT_W-1];
   end

   assign rot_start = accept && (req.command == CMD_SAMPLE) && !full;

   ibac_rotator u_rot (
      .clock (clock), .reset (reset), .start (rot_start),
      .ax (ax_n), .az (az_n), .gx (gx_n), .gz (gz_n),
      .c (cos_ff[req.sensor]), .s (sin_ff[req.sensor]),
      .done (rot_done), .ax2 (ax2), .az2 (az2), .gx2 (gx2), .gz2 (gz2)
   );

   // Rotation samples add the gyro triple, which sits in the upper half of vals.
   assign sel = smp_rot_ff ? k_ff[2:0] + 3'd3 : k_ff[2:0];
   assign acc_addr = sum_addr(smp_sensor_ff, smp_rot_ff, k_ff[2:0]);
   assign cmp_addr = (k_ff < 4'd6) ? sum_addr(sens_ff, 1'b0, k_ff[2:0])
                                   : sum_addr(sens_ff, 1'b1, 3'(k_ff - 4'd6));
   assign raddr = (state_ff == S_C_RD) ? cmp_addr : acc_addr;
   assign cur_sum = rvld_ff ? $signed(rdata) : '0;
   assign wdata = SUM_W'(cur_sum + vals_ff[sel]);
   assign ram_we = (state_ff == S_ACC_WR);

   ibac_ram #(.WIDTH (SUM_W), .DEPTH (NSUM)) u_sums (
      .clock (clock), .we (ram_we), .waddr (acc_addr), .wdata (wdata),
      .raddr (raddr), .rdata (rdata)
   );

   // Corrected rotation means and the projection numerator -r * 2^16.
   assign rx = R_W'(mean_ff[6]) - R_W'(mean_ff[3]);
   assign ry = R_W'(mean_ff[7]) - R_W'(mean_ff[4]);
   assign rz = R_W'(mean_ff[8]) - R_W'(mean_ff[5]);
   assign arz = rz[R_W-1] ? R_W'(-rz) : R_W'(rz);
   assign rsel = pk_ff ? ry : rx;
   assign pnum = NUM_W'(-(NUM_W'(rsel))) <<< 16;

   always_comb begin
      if (state_ff == S_P_LD) begin
         div_num = pnum;
         div_den = DEN_W'(rz);
      end else begin
         div_num = NUM_W'(cur_sum);
         div_den = (k_ff < 4'd6) ? DEN_W'({1'b0, scnt_ff[sens_ff]})
                                 : DEN_W'({1'b0, rcnt_ff[sens_ff]});
      end
   end
   assign div_start = (state_ff == S_C_LD) || (state_ff == S_P_LD);

   ibac_divider u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .num (div_num), .den (div_den), .done (div_done), .quo (div_quo)
   );

   always_ff @(posedge clock) begin
      if (rsp.valid && rsp.ready) o_v_ff <= 1'b0;
      if (csr_we) begin
         case (csr_index)
            REG_COS_FIRST: cos_ff[0] <= csr_wdata;
            REG_SIN_FIRST: sin_ff[0] <= csr_wdata;
            REG_COS_SECOND: cos_ff[1] <= csr_wdata;
            REG_SIN_SECOND: sin_ff[1] <= csr_wdata;
            REG_GRAVITY: grav_ff <= csr_wdata[GRAV_W-1:0];
            REG_MIN_ROT: minrot_ff <= csr_wdata[GRAV_W-1:0];
            default: ;
         endcase
      end
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               smp_sensor_ff <= req.sensor;
               smp_rot_ff <= (req.phase == PH_ROT);
               ay_ff <= -NEG_W'(req.accel_y);
               gy_ff <= -NEG_W'(req.gyro_y);
               case (req.command)
                  CMD_SAMPLE: if (!full) state_ff <= S_ROT;
                  CMD_COMPUTE: begin
                     sens_ff <= 1'b0;
                     state_ff <= S_CHK;
                  end
                  CMD_CLEAR: begin
                     valid_ff <= '0;
                     scnt_ff[0] <= '0;
                     scnt_ff[1] <= '0;
                     rcnt_ff[0] <= '0;
                     rcnt_ff[1] <= '0;
                  end
                  default: ;
               endcase
            end
         end
         S_ROT: begin
            if (rot_done) begin
               vals_ff[0] <= SUM_W'(ax2);
               vals_ff[1] <= SUM_W'(ay_ff);
               vals_ff[2] <= SUM_W'(az2);
               vals_ff[3] <= SUM_W'(gx2);
               vals_ff[4] <= SUM_W'(gy_ff);
               vals_ff[5] <= SUM_W'(gz2);
               k_ff <= '0;
               state_ff <= S_ACC_RD;
            end
         end
         S_ACC_RD: begin
            rvld_ff <= valid_ff[acc_addr];
            state_ff <= S_ACC_WR;
         end
         S_ACC_WR: begin
            valid_ff[acc_addr] <= 1'b1;
            k_ff <= k_ff + 1'b1;
            state_ff <= S_ACC_RD;
            if (smp_rot_ff && k_ff == 4'd2) begin
               rcnt_ff[smp_sensor_ff] <= rcnt_ff[smp_sensor_ff] + 1'b1;
               state_ff <= S_IDLE;
            end else if (!smp_rot_ff && k_ff == 4'd5) begin
               scnt_ff[smp_sensor_ff] <= scnt_ff[smp_sensor_ff] + 1'b1;
               state_ff <= S_IDLE;
            end
         end
         S_CHK: begin
            k_ff <= '0;
            vld_ff <= 1'b0;
            px_ff <= '0;
            py_ff <= '0;
            pk_ff <= 1'b0;
            emp_ff <= (scnt_ff[sens_ff] == '0) || (rcnt_ff[sens_ff] == '0);
            if ((scnt_ff[sens_ff] == '0) || (rcnt_ff[sens_ff] == '0)) state_ff <= S_OUT;
            else state_ff <= S_C_RD;
         end
         S_C_RD: begin
            rvld_ff <= valid_ff[cmp_addr];
            state_ff <= S_C_LD;
         end
         S_C_LD: state_ff <= S_C_DIV;
         S_C_DIV: begin
            if (div_done) begin
               mean_ff[k_ff] <= div_quo[MEAN_W-1:0];
               k_ff <= k_ff + 1'b1;
               state_ff <= (k_ff == 4'(NMEAN - 1)) ? S_P_LD : S_C_RD;
               if (k_ff == 4'(NMEAN - 1)) pk_ff <= 1'b0;
            end
         end
         S_P_LD: begin
            // A weak z rotation gives no projection.
            if (arz > R_W'(minrot_ff)) state_ff <= S_P_DIV;
            else state_ff <= S_OUT;
         end
         S_P_DIV: begin
            if (div_done) begin
               if (!pk_ff) begin
                  px_ff <= sat32(div_quo);
                  pk_ff <= 1'b1;
                  state_ff <= S_P_LD;
               end else begin
                  py_ff <= sat32(div_quo);
                  vld_ff <= 1'b1;
                  state_ff <= S_OUT;
               end
            end
         end
         S_OUT: begin
            if (out_free) begin
               o_v_ff <= 1'b1;
               o_sensor_ff <= sens_ff;
               o_valid_ff <= vld_ff;
               for (int i = 0; i < 6; i++) begin
                  o_bias_ff[i] <= emp_ff ? '0 : sat16(Q_W'(mean_ff[i]));
               end
               if (!emp_ff) o_bias_ff[2] <= sat16(Q_W'(mean_ff[2]) - Q_W'({1'b0, grav_ff}));
               o_px_ff <= vld_ff ? px_ff : '0;
               o_py_ff <= vld_ff ? py_ff : '0;
               if (!sens_ff) begin
                  sens_ff <= 1'b1;
                  state_ff <= S_CHK;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
         end
         default: state_ff <= S_IDLE;
      endcase
      if (reset) begin
         state_ff <= S_IDLE;
         o_v_ff <= 1'b0;
         valid_ff <= '0;
         scnt_ff[0] <= '0;
         scnt_ff[1] <= '0;
         rcnt_ff[0] <= '0;
         rcnt_ff[1] <= '0;
         cos_ff[0] <= RST_COS_FIRST;
         sin_ff[0] <= RST_SIN_FIRST;
         cos_ff[1] <= RST_COS_SECOND;
         sin_ff[1] <= RST_SIN_SECOND;
         grav_ff <= RST_GRAVITY;
         minrot_ff <= RST_MIN_ROT;
      end
   end

   assign rsp.valid = o_v_ff;
   assign rsp.result_sensor = o_sensor_ff;
   assign rsp.valid_res = o_valid_ff;
   assign rsp.accel_bias_x = o_bias_ff[0];
   assign rsp.accel_bias_y = o_bias_ff[1];
   assign rsp.accel_bias_z = o_bias_ff[2];
   assign rsp.gyro_bias_x = o_bias_ff[3];
   assign rsp.gyro_bias_y = o_bias_ff[4];
   assign rsp.gyro_bias_z = o_bias_ff[5];
   assign rsp.proj_z_to_x = o_px_ff;
   assign rsp.proj_z_to_y = o_py_ff;
   assign rsp.last = o_sensor_ff;
endmodule

>>> src/ibac_checker.sv
`timescale 1ns / 1ps
`include "imu_bias_alignment_calibrator_core_assert.svh"
module ibac_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_result_sensor,
   input logic        rsp_valid_res,
   input logic        rsp_last,
   input logic [31:0] rsp_proj_z_to_x,
   input logic [31:0] rsp_proj_z_to_y
);
   `IBAC_ASSERT(a_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_proj_z_to_x))
   `IBAC_ASSERT(a_last, rsp_valid |-> rsp_last == rsp_result_sensor)
   `IBAC_ASSERT(a_busy, rsp_valid && !rsp_result_sensor |-> !req_ready)
   `IBAC_ASSERT(a_proj, rsp_valid && !rsp_valid_res |-> !(|{rsp_proj_z_to_x, rsp_proj_z_to_y}))
   `IBAC_ASSERT_RST(a_rst, reset |=> !rsp_valid)
endmodule

bind imu_bias_alignment_calibrator_core ibac_checker u_ibac_checker (
   .clock (clock), .reset (reset), .req_ready (req.ready),
   .rsp_valid (rsp.valid), .rsp_ready (rsp.ready), .rsp_result_sensor (rsp.result_sensor),
   .rsp_valid_res (rsp.valid_res), .rsp_last (rsp.last),
   .rsp_proj_z_to_x (rsp.proj_z_to_x), .rsp_proj_z_to_y (rsp.proj_z_to_y)
);

>>> tb/sv/tb_imu_bias_alignment_calibrator_core.sv
`timescale 1ns / 1ps
module tb_imu_bias_alignment_calibrator_core;
   import ibac_pkg::*;

   // Codes that the package leaves unnamed: the unused command and the two
   // discarding phases.
   localparam logic [1:0] CMD_SPARE   = 2'd3;
   localparam logic [1:0] PH_DISCARD  = 2'd0;
   localparam logic [1:0] PH_SPARE    = 2'd3;
   localparam int         SET_LIMIT   = 65536;
   localparam int         SETTLE_CYC  = 60;

   typedef struct {
      logic [1:0] command;
      logic       sensor;
      logic [1:0] phase;
      smp_type    gyro_x, gyro_y, gyro_z;
      smp_type    accel_x, accel_y, accel_z;
   } imu_cmd_t;

   typedef struct {
      logic               result_sensor;
      logic               valid_res;
      smp_type            accel_bias_x, accel_bias_y, accel_bias_z;
      smp_type            gyro_bias_x, gyro_bias_y, gyro_bias_z;
      logic signed [31:0] proj_z_to_x, proj_z_to_y;
      logic               last;
   } calib_result_t;

   // A directed row; when typed_empty is set the two results are written out
   // here as empty, invalid results instead of being taken from the predictor.
   typedef struct {
      imu_cmd_t cmd;
      bit       typed_empty;
   } directed_row_t;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CF_W-1:0]      csr_wdata;

   ibac_req_if req_ch();
   ibac_rsp_if rsp_ch();

   imu_bias_alignment_calibrator_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the configuration and of the accumulated sums.
   logic signed [15:0] tilt_cos [2];
   logic signed [15:0] tilt_sin [2];
   logic [14:0]        gravity_q10;
   logic [14:0]        min_rot_q10;
   longint             static_acc [12];
   longint             rotation_acc [6];
   int                 static_n [2];
   int                 rotation_n [2];

   calib_result_t calib_results_due [$];
   int            mismatch_count = 0;

   // Knobs for the sender and the receiver.
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_ticket = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Mismatches found");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Appends one expected result to the end of the queue.
   function automatic void expect_result(calib_result_t r);
      calib_results_due.insert(calib_results_due.size(), r);
   endfunction

   // Q1.14 product sum back to Q.10: add half and shift with floor.
   function automatic longint round_tilt(longint p);
      return (p + 8192) >>> 14;
   endfunction

   // Division rounded to nearest, halves away from zero.
   function automatic longint div_nearest(longint n, longint d);
      longint an, ad, q;
      an = n < 0 ? -n : n;
      ad = d < 0 ? -d : d;
      q = (an + ad / 2) / ad;
      return ((n < 0) != (d < 0)) ? -q : q;
   endfunction

   function automatic longint clamp_signed(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   function automatic void clear_sums();
      foreach (static_acc[i]) static_acc[i] = 0;
      foreach (rotation_acc[i]) rotation_acc[i] = 0;
      static_n = '{0, 0};
      rotation_n = '{0, 0};
   endfunction

   function automatic void accumulate_sample(imu_cmd_t c);
      int s;
      longint cf, sn, gx, gy, gz, ax, ay, az, gx_r, gz_r, ax_r, az_r;
      s = c.sensor;
      cf = tilt_cos[s];
      sn = tilt_sin[s];
      // The y and z axes are flipped before the tilt is taken out.
      gx = c.gyro_x;
      gy = -longint'(c.gyro_y);
      gz = -longint'(c.gyro_z);
      ax = c.accel_x;
      ay = -longint'(c.accel_y);
      az = -longint'(c.accel_z);
      gx_r = round_tilt(gx * cf - gz * sn);
      gz_r = round_tilt(gx * sn + gz * cf);
      ax_r = round_tilt(ax * cf - az * sn);
      az_r = round_tilt(ax * sn + az * cf);
      if (c.phase == PH_STATIC && static_n[s] < SET_LIMIT) begin
         static_acc[6*s+0] += ax_r;
         static_acc[6*s+1] += ay;
         static_acc[6*s+2] += az_r;
         static_acc[6*s+3] += gx_r;
         static_acc[6*s+4] += gy;
         static_acc[6*s+5] += gz_r;
         static_n[s]++;
      end else if (c.phase == PH_ROT && rotation_n[s] < SET_LIMIT) begin
         rotation_acc[3*s+0] += gx_r;
         rotation_acc[3*s+1] += gy;
         rotation_acc[3*s+2] += gz_r;
         rotation_n[s]++;
      end
   endfunction

   function automatic calib_result_t sensor_calibration(int s);
      calib_result_t r;
      longint mean [6];
      longint rx, ry, rz, px, py;
      bit ok;
      foreach (mean[i]) mean[i] = 0;
      px = 0;
      py = 0;
      ok = 0;
      if (static_n[s] != 0 && rotation_n[s] != 0) begin
         for (int i = 0; i < 6; i++) mean[i] = div_nearest(static_acc[6*s+i], static_n[s]);
         // The rotation is corrected with the unsaturated gyro bias.
         rx = div_nearest(rotation_acc[3*s+0], rotation_n[s]) - mean[3];
         ry = div_nearest(rotation_acc[3*s+1], rotation_n[s]) - mean[4];
         rz = div_nearest(rotation_acc[3*s+2], rotation_n[s]) - mean[5];
         mean[2] -= longint'(gravity_q10);
         if ((rz < 0 ? -rz : rz) > longint'(min_rot_q10)) begin
            px = clamp_signed(div_nearest(-rx * 65536, rz), 32);
            py = clamp_signed(div_nearest(-ry * 65536, rz), 32);
            ok = 1;
         end
      end
      r.result_sensor = s[0];
      r.valid_res = ok;
      r.accel_bias_x = clamp_signed(mean[0], 16);
      r.accel_bias_y = clamp_signed(mean[1], 16);
      r.accel_bias_z = clamp_signed(mean[2], 16);
      r.gyro_bias_x = clamp_signed(mean[3], 16);
      r.gyro_bias_y = clamp_signed(mean[4], 16);
      r.gyro_bias_z = clamp_signed(mean[5], 16);
      r.proj_z_to_x = px;
      r.proj_z_to_y = py;
      r.last = (s == 1);
      return r;
   endfunction

   function automatic void predict_transaction(imu_cmd_t c);
      case (c.command)
         CMD_SAMPLE: accumulate_sample(c);
         CMD_COMPUTE: begin
            expect_result(sensor_calibration(0));
            expect_result(sensor_calibration(1));
         end
         CMD_CLEAR: clear_sums();
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Result side: the receiver stalls at random, and on request holds off for
   // a long stretch that it counts down itself.
   // ---------------------------------------------------------------------
   initial begin
      int seen_ticket;
      int hold_left;
      seen_ticket = 0;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ticket != seen_ticket) begin
            seen_ticket = hold_ticket;
            hold_left = 3000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   function automatic void check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      calib_result_t e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (calib_results_due.size() == 0) begin
            $error("result transaction with no expectation pending");
            mismatch_count++;
         end else begin
            e = calib_results_due.pop_front();
            check_field("result_sensor", e.result_sensor, rsp_ch.result_sensor);
            check_field("valid_res", e.valid_res, rsp_ch.valid_res);
            check_field("accel_bias_x", e.accel_bias_x, rsp_ch.accel_bias_x);
            check_field("accel_bias_y", e.accel_bias_y, rsp_ch.accel_bias_y);
            check_field("accel_bias_z", e.accel_bias_z, rsp_ch.accel_bias_z);
            check_field("gyro_bias_x", e.gyro_bias_x, rsp_ch.gyro_bias_x);
            check_field("gyro_bias_y", e.gyro_bias_y, rsp_ch.gyro_bias_y);
            check_field("gyro_bias_z", e.gyro_bias_z, rsp_ch.gyro_bias_z);
            check_field("proj_z_to_x", e.proj_z_to_x, rsp_ch.proj_z_to_x);
            check_field("proj_z_to_y", e.proj_z_to_y, rsp_ch.proj_z_to_y);
            check_field("last", e.last, rsp_ch.last);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Command side
   // ---------------------------------------------------------------------

   // Offers one transaction, with an optional gap first, and feeds the
   // predictor once it has been taken.
   task automatic send_command(imu_cmd_t c);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= c.command;
      req_ch.sensor  <= c.sensor;
      req_ch.phase   <= c.phase;
      req_ch.gyro_x  <= c.gyro_x;
      req_ch.gyro_y  <= c.gyro_y;
      req_ch.gyro_z  <= c.gyro_z;
      req_ch.accel_x <= c.accel_x;
      req_ch.accel_y <= c.accel_y;
      req_ch.accel_z <= c.accel_z;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_transaction(c);
   endtask

   // Waits until every outstanding result has come back, then lets the block
   // finish any sample still in flight, which produces no result.
   task automatic drain_results();
      int guard;
      guard = 0;
      req_ch.valid <= 1'b0;
      while (calib_results_due.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_config(logic signed [15:0] c0, logic signed [15:0] s0,
                               logic signed [15:0] c1, logic signed [15:0] s1,
                               logic [14:0] grav, logic [14:0] min_rot);
      logic [15:0] vals [6];
      logic [CSR_IDX_W-1:0] idx [6];
      vals = '{c0, s0, c1, s1, {1'b0, grav}, {1'b0, min_rot}};
      idx = '{REG_COS_FIRST, REG_SIN_FIRST, REG_COS_SECOND, REG_SIN_SECOND,
              REG_GRAVITY, REG_MIN_ROT};
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      tilt_cos = '{c0, c1};
      tilt_sin = '{s0, s1};
      gravity_q10 = grav;
      min_rot_q10 = min_rot;
   endtask

   // Sample values lean towards the two extremes so that saturation is hit.
   function automatic smp_type sample_value();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return 16'sh8000;
      if (pick == 1) return 16'sh7fff;
      return smp_type'($urandom());
   endfunction

   function automatic imu_cmd_t make_cmd(logic [1:0] cmd, logic s, logic [1:0] ph,
                                         smp_type gx, smp_type gy, smp_type gz,
                                         smp_type ax, smp_type ay, smp_type az);
      imu_cmd_t c;
      c = '{cmd, s, ph, gx, gy, gz, ax, ay, az};
      return c;
   endfunction

   // Appends one row to the directed table.
   function automatic void add_row(ref directed_row_t rows [$], input imu_cmd_t c,
                                   input bit typed);
      directed_row_t r;
      r.cmd = c;
      r.typed_empty = typed;
      rows.insert(rows.size(), r);
   endfunction

   function automatic imu_cmd_t random_sample(logic [1:0] ph);
      return make_cmd(CMD_SAMPLE, $urandom_range(1), ph, sample_value(), sample_value(),
                      sample_value(), sample_value(), sample_value(), sample_value());
   endfunction

   // Mostly complete calibration runs with random content: an optional clear,
   // a burst of static and rotation samples with some discarded ones mixed in,
   // then a compute. The rest is loose noise over every code.
   task automatic random_traffic(int target);
      int sent;
      int n;
      imu_cmd_t c;
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(9) < 8) begin
            if ($urandom_range(3) == 0) begin
               send_command(make_cmd(CMD_CLEAR, $urandom_range(1), $urandom_range(3),
                                     sample_value(), sample_value(), sample_value(),
                                     sample_value(), sample_value(), sample_value()));
               sent++;
            end
            n = $urandom_range(2, 12);
            repeat (n) begin
               if ($urandom_range(9) == 0) begin
                  send_command(random_sample($urandom_range(1) ? PH_DISCARD : PH_SPARE));
               end else begin
                  send_command(random_sample($urandom_range(1) ? PH_STATIC : PH_ROT));
               end
               sent++;
            end
            send_command(make_cmd(CMD_COMPUTE, $urandom_range(1), $urandom_range(3),
                                  sample_value(), sample_value(), sample_value(),
                                  sample_value(), sample_value(), sample_value()));
            sent++;
         end else begin
            c = make_cmd($urandom_range(3), $urandom_range(1), $urandom_range(3),
                         sample_value(), sample_value(), sample_value(),
                         sample_value(), sample_value(), sample_value());
            send_command(c);
            sent++;
         end
      end
   endtask

   function automatic logic signed [15:0] random_coef();
      int pick;
      pick = $urandom_range(5);
      if (pick == 0) return -16'sd16384;
      if (pick == 1) return 16'sd16384;
      return $urandom_range(32768) - 16384;
   endfunction

   initial begin
      directed_row_t directed [$];
      calib_result_t empty_res;
      smp_type hi;
      smp_type lo;
      hi = 16'sh7fff;
      lo = 16'sh8000;

      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.command <= CMD_SAMPLE;
      req_ch.sensor <= 1'b0;
      req_ch.phase <= PH_DISCARD;
      req_ch.gyro_x <= '0;
      req_ch.gyro_y <= '0;
      req_ch.gyro_z <= '0;
      req_ch.accel_x <= '0;
      req_ch.accel_y <= '0;
      req_ch.accel_z <= '0;
      tilt_cos = '{RST_COS_FIRST, RST_COS_SECOND};
      tilt_sin = '{RST_SIN_FIRST, RST_SIN_SECOND};
      gravity_q10 = RST_GRAVITY;
      min_rot_q10 = RST_MIN_ROT;
      clear_sums();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, run with the reset configuration.
      add_row(directed, make_cmd(CMD_COMPUTE, 0, PH_DISCARD, 0, 0, 0, 0, 0, 0), 1);
      add_row(directed, make_cmd(CMD_SPARE, 1, PH_STATIC, hi, hi, hi, hi, hi, hi), 0);
      add_row(directed, make_cmd(CMD_SAMPLE, 0, PH_DISCARD, hi, lo, hi, lo, hi, lo), 0);
      add_row(directed, make_cmd(CMD_SAMPLE, 1, PH_SPARE, lo, hi, lo, hi, lo, hi), 0);
      add_row(directed, make_cmd(CMD_COMPUTE, 1, PH_ROT, 0, 0, 0, 0, 0, 0), 1);
      add_row(directed, make_cmd(CMD_SAMPLE, 0, PH_STATIC, hi, hi, hi, hi, hi, hi), 0);
      add_row(directed, make_cmd(CMD_SAMPLE, 0, PH_STATIC, lo, lo, lo, lo, lo, lo), 0);
      add_row(directed, make_cmd(CMD_SAMPLE, 0, PH_ROT, hi, lo, hi, 0, 0, 0), 0);
      add_row(directed, make_cmd(CMD_COMPUTE, 0, PH_DISCARD, 0, 0, 0, 0, 0, 0), 0);
      add_row(directed, make_cmd(CMD_SAMPLE, 1, PH_STATIC, lo, hi, lo, hi, lo, hi), 0);
      add_row(directed, make_cmd(CMD_SAMPLE, 1, PH_ROT, 0, 0, lo, 0, 0, 0), 0);
      add_row(directed, make_cmd(CMD_SAMPLE, 1, PH_ROT, lo, hi, hi, 0, 0, 0), 0);
      add_row(directed, make_cmd(CMD_COMPUTE, 0, PH_DISCARD, 0, 0, 0, 0, 0, 0), 0);
      add_row(directed, make_cmd(CMD_CLEAR, 0, PH_DISCARD, 0, 0, 0, 0, 0, 0), 0);
      add_row(directed, make_cmd(CMD_COMPUTE, 0, PH_DISCARD, 0, 0, 0, 0, 0, 0), 1);
      // Identical static and rotation samples give no z rotation at all.
      add_row(directed, make_cmd(CMD_SAMPLE, 0, PH_STATIC, 700, -300, 900, 50, 40, -10050), 0);
      add_row(directed, make_cmd(CMD_SAMPLE, 0, PH_ROT, 700, -300, 900, 0, 0, 0), 0);
      // The second sensor gets static data only, so its rotation set is empty.
      add_row(directed, make_cmd(CMD_SAMPLE, 1, PH_STATIC, 5, 6, 7, 8, 9, 10), 0);
      add_row(directed, make_cmd(CMD_COMPUTE, 0, PH_DISCARD, 0, 0, 0, 0, 0, 0), 0);
      add_row(directed, make_cmd(CMD_CLEAR, 1, PH_ROT, 0, 0, 0, 0, 0, 0), 0);

      foreach (directed[i]) begin
         if (directed[i].typed_empty) begin
            // The sums are empty here, so both results are known outright.
            send_command(directed[i].cmd);
            void'(calib_results_due.pop_back());
            void'(calib_results_due.pop_back());
            empty_res = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
            expect_result(empty_res);
            empty_res.result_sensor = 1;
            empty_res.last = 1;
            expect_result(empty_res);
         end else begin
            send_command(directed[i].cmd);
         end
      end
      drain_results();

      // Random phases, each under its own configuration and one of four idling patterns.
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: write_config(16'sd16384, 16'sd0, -16'sd16384, 16'sd16384, 15'd0, 15'd0);
            1: write_config(-16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384,
                            15'd32767, 15'd32767);
            3: write_config(RST_COS_FIRST, RST_SIN_FIRST, RST_COS_SECOND, RST_SIN_SECOND,
                            RST_GRAVITY, RST_MIN_ROT);
            4: write_config(16'sd0, 16'sd16384, 16'sd0, -16'sd16384, 15'd10045, 15'd1);
            default: write_config(random_coef(), random_coef(), random_coef(), random_coef(),
                                  $urandom_range(32767), $urandom_range(3000));
         endcase
         case (p % 4)
            0: begin sender_idle_pct <= 0;  receiver_stall_pct <= 0;  end
            1: begin sender_idle_pct <= 80; receiver_stall_pct <= 0;  end
            2: begin sender_idle_pct <= 0;  receiver_stall_pct <= 80; end
            default: begin sender_idle_pct <= 10; receiver_stall_pct <= 10; end
         endcase
         // In the first phase the receiver holds off for a long stretch while
         // commands keep coming, so the block backs up and stalls its input.
         if (p == 0) hold_ticket <= hold_ticket + 1;
         @(posedge clock);
         random_traffic(76);
         drain_results();
      end

      if (calib_results_due.size() != 0) begin
         $error("%0d expected results never arrived", calib_results_due.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

>>> filelist.f
+incdir+src
src/ibac_pkg.sv
src/ibac_if.sv
src/ibac_ram.sv
src/ibac_rotator.sv
src/ibac_divider.sv
src/imu_bias_alignment_calibrator_core.sv
src/ibac_checker.sv
tb/sv/tb_imu_bias_alignment_calibrator_core.sv
